>>> hw/rtl/assert_macros.svh
// Assertion macros for the RTL files, included by the command engine
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check a property on every clock edge, disabled during reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check a property on every clock edge, including reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

>>> hw/rtl/snfcs_pkg.sv
// Package with codes, types and constants for the flash command sequencer
package snfcs_pkg;

  localparam int PageBytes = 256;
  localparam int PageBits = 8;
  localparam int AddrBits = 24;
  localparam int CountBits = 16;
  localparam int ChunkBits = PageBits + 1;

  // Item kinds
  localparam logic [1:0] FUNC_CMD = 2'd0;
  localparam logic [1:0] FUNC_DATA = 2'd1;
  localparam logic [1:0] FUNC_RX = 2'd2;
  localparam logic [1:0] FUNC_RSVD = 2'd3;

  // Commands
  localparam logic [2:0] OP_READ = 3'd0;
  localparam logic [2:0] OP_PROG = 3'd1;
  localparam logic [2:0] OP_SERASE = 3'd2;
  localparam logic [2:0] OP_CERASE = 3'd3;
  localparam logic [2:0] OP_WRSR = 3'd4;
  localparam logic [2:0] OP_RDSR = 3'd5;
  localparam logic [2:0] OP_RDID = 3'd6;
  localparam logic [2:0] OP_NOP = 3'd7;

  // Result kinds
  localparam logic [1:0] RK_XFER = 2'd0;
  localparam logic [1:0] RK_RDATA = 2'd1;
  localparam logic [1:0] RK_DONE = 2'd2;
  localparam logic [1:0] RK_REQ = 2'd3;

  // Flash opcodes
  localparam logic [7:0] FL_WREN = 8'h06;
  localparam logic [7:0] FL_RDSR = 8'h05;
  localparam logic [7:0] FL_PP = 8'h02;
  localparam logic [7:0] FL_READ = 8'h03;
  localparam logic [7:0] FL_WRSR = 8'h01;
  localparam logic [7:0] FL_RDID = 8'h9f;
  localparam logic [7:0] FL_CE = 8'hC7;

  // Config register indexes
  localparam logic CFG_ERASE_OP = 1'b0;
  localparam logic CFG_SECT_SHIFT = 1'b1;

  typedef enum logic [11:0] {
    PH_IDLE   = 12'b000000000001,
    PH_WREN   = 12'b000000000010,
    PH_POLLC  = 12'b000000000100,
    PH_POLLD  = 12'b000000001000,
    PH_CMD    = 12'b000000010000,
    PH_ADDR   = 12'b000000100000,
    PH_RD     = 12'b000001000000,
    PH_WAITH  = 12'b000010000000,
    PH_WD     = 12'b000100000000,
    PH_NEXT   = 12'b001000000000,
    PH_TAIL   = 12'b010000000000,
    PH_FINISH = 12'b100000000000
  } phase_t;

  // Classified word handed from front to back
  typedef struct packed {
    logic [1:0] func;
    logic [2:0] op;
    logic [AddrBits-1:0] start_addr;
    logic [CountBits-1:0] byte_count;
    logic [7:0] wdata;
    logic [7:0] rx_byte;
  } item_t;

  // One result word
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] tx;
    logic fe;
    logic [7:0] rd;
  } res_t;

  localparam int ItemBits = $bits(item_t);

endpackage

>>> hw/rtl/snfcs_front.sv
// Front end: accept input words, drop code 3, queue them for the engine
module snfcs_front (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  snfcs_pkg::item_t in_item,
  output logic q_valid,
  input  logic q_pop,
  output snfcs_pkg::item_t q_item
);

  logic [snfcs_pkg::ItemBits-1:0] mem [2];
  logic wp;
  logic rp;
  logic [1:0] cnt;
  logic push;
  logic keep;

  // Drop words of the unused function code at the door
  assign keep = (in_item.func != snfcs_pkg::FUNC_RSVD);
  assign in_stall = (cnt == 2'd2);
  assign push = in_valid && !in_stall && keep;
  assign q_valid = (cnt != 2'd0);
  assign q_item = snfcs_pkg::item_t'(mem[rp]);

  // Hold queued words
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= in_item;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (q_pop) begin
        rp <= ~rp;
      end
      cnt <= cnt + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

>>> hw/rtl/snfcs_engine.sv
// Back end: command engine that emits up to two result words per item
module snfcs_engine (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [7:0] cfg_data,
  input  logic q_valid,
  output logic q_pop,
  input  snfcs_pkg::item_t q_item,
  output logic out_valid,
  input  logic out_stall,
  output snfcs_pkg::res_t out_res,
  output logic out_last
);

  `include "assert_macros.svh"

  localparam int AB = snfcs_pkg::AddrBits;
  localparam int CB = snfcs_pkg::CountBits;
  localparam int HB = snfcs_pkg::ChunkBits;

  logic [7:0] erase_opcode;
  logic [4:0] sector_shift;

  snfcs_pkg::phase_t phase, phase_next, resume_phase, resume_phase_next;
  logic [2:0] current_command, current_command_next;
  logic [AB-1:0] cursor_addr, cursor_addr_next;
  logic [CB-1:0] bytes_left, bytes_left_next;
  logic [HB-1:0] chunk_left, chunk_left_next;
  logic [1:0] frame_pos, frame_pos_next;

  // Result buffer: three entries, of which one item fills up to two
  snfcs_pkg::res_t buf_res [3];
  snfcs_pkg::res_t buf_next [3];
  logic [1:0] buf_cnt, buf_cnt_next;
  logic [1:0] buf_rd;
  logic [1:0] n;

  logic take;
  logic [AB:0] step;
  logic [AB-1:0] room;

  // Take the next word when the buffer is empty or its last word leaves now
  assign q_pop = q_valid && ((buf_cnt == 2'd0) || (out_valid && !out_stall && out_last));
  assign take = q_pop;
  assign out_valid = (buf_cnt != 2'd0);
  assign out_res = buf_res[buf_rd];
  assign out_last = (buf_rd == buf_cnt - 2'd1);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      erase_opcode <= 8'h20;
      sector_shift <= 5'd12;
    end else if (cfg_we) begin
      case (cfg_index)
        snfcs_pkg::CFG_ERASE_OP: erase_opcode <= cfg_data;
        snfcs_pkg::CFG_SECT_SHIFT: sector_shift <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // Step for the erase loop; a shift past the address width acts as one full wrap
  always_comb begin
    step = '0;
    if (int'(sector_shift) <= AB) begin
      step[sector_shift] = 1'b1;
    end else begin
      step[AB] = 1'b1;
    end
  end

  // Sequence one item into result words
  always_comb begin
    snfcs_pkg::phase_t ent;
    logic [7:0] opb;
    logic [CB:0] bl_sub;
    logic [HB-1:0] rm;
    logic [2:0] fp;
    phase_next = phase;
    resume_phase_next = resume_phase;
    current_command_next = current_command;
    cursor_addr_next = cursor_addr;
    bytes_left_next = bytes_left;
    chunk_left_next = chunk_left;
    frame_pos_next = frame_pos;
    n = 2'd0;
    buf_next = '{default: '0};
    ent = snfcs_pkg::PH_IDLE;
    opb = '0;
    bl_sub = '0;
    rm = '0;
    fp = '0;
    room = '0;
    if (take) begin
      // Decode the item into an immediate action and a phase to enter
      case (q_item.func)
        snfcs_pkg::FUNC_CMD: begin
          if (phase == snfcs_pkg::PH_IDLE) begin
            current_command_next = q_item.op;
            cursor_addr_next = q_item.start_addr;
            bytes_left_next = q_item.byte_count;
            chunk_left_next = '0;
            frame_pos_next = '0;
            case (q_item.op)
              snfcs_pkg::OP_READ: ent = snfcs_pkg::PH_CMD;
              snfcs_pkg::OP_PROG, snfcs_pkg::OP_SERASE: ent = snfcs_pkg::PH_NEXT;
              snfcs_pkg::OP_CERASE: ent = snfcs_pkg::PH_WREN;
              snfcs_pkg::OP_WRSR: begin
                cursor_addr_next = AB'(q_item.wdata);
                ent = snfcs_pkg::PH_WREN;
              end
              snfcs_pkg::OP_RDSR: begin
                bytes_left_next = CB'(1);
                ent = snfcs_pkg::PH_CMD;
              end
              snfcs_pkg::OP_RDID: begin
                bytes_left_next = CB'(3);
                resume_phase_next = snfcs_pkg::PH_CMD;
                ent = snfcs_pkg::PH_POLLC;
              end
              default: ent = snfcs_pkg::PH_FINISH;
            endcase
          end
        end
        snfcs_pkg::FUNC_DATA: begin
          if (phase == snfcs_pkg::PH_WAITH) begin
            phase_next = snfcs_pkg::PH_WD;
            buf_next[0] = '{snfcs_pkg::RK_XFER, q_item.wdata,
                            chunk_left == HB'(1), 8'h00};
            n = 2'd1;
          end
        end
        snfcs_pkg::FUNC_RX: begin
          case (phase)
            snfcs_pkg::PH_WREN: begin
              resume_phase_next = snfcs_pkg::PH_CMD;
              ent = snfcs_pkg::PH_POLLC;
            end
            snfcs_pkg::PH_POLLC: begin
              phase_next = snfcs_pkg::PH_POLLD;
              buf_next[0] = '{snfcs_pkg::RK_XFER, 8'h00, 1'b1, 8'h00};
              n = 2'd1;
            end
            snfcs_pkg::PH_POLLD: begin
              ent = q_item.rx_byte[0] ? snfcs_pkg::PH_POLLC : resume_phase;
            end
            snfcs_pkg::PH_CMD: begin
              case (current_command)
                snfcs_pkg::OP_READ, snfcs_pkg::OP_PROG, snfcs_pkg::OP_SERASE: begin
                  phase_next = snfcs_pkg::PH_ADDR;
                  frame_pos_next = '0;
                  buf_next[0] = '{snfcs_pkg::RK_XFER, cursor_addr[23:16], 1'b0, 8'h00};
                  n = 2'd1;
                end
                snfcs_pkg::OP_CERASE: begin
                  resume_phase_next = snfcs_pkg::PH_FINISH;
                  ent = snfcs_pkg::PH_POLLC;
                end
                snfcs_pkg::OP_WRSR: begin
                  phase_next = snfcs_pkg::PH_TAIL;
                  buf_next[0] = '{snfcs_pkg::RK_XFER, cursor_addr[7:0], 1'b1, 8'h00};
                  n = 2'd1;
                end
                default: begin
                  phase_next = snfcs_pkg::PH_RD;
                  buf_next[0] = '{snfcs_pkg::RK_XFER, 8'h00,
                                  bytes_left == CB'(1), 8'h00};
                  n = 2'd1;
                end
              endcase
            end
            snfcs_pkg::PH_ADDR: begin
              fp = {1'b0, frame_pos} + 3'd1;
              frame_pos_next = fp[1:0];
              if (fp == 3'd1) begin
                buf_next[0] = '{snfcs_pkg::RK_XFER, cursor_addr[15:8], 1'b0, 8'h00};
                n = 2'd1;
              end else if (fp == 3'd2) begin
                buf_next[0] = '{snfcs_pkg::RK_XFER, cursor_addr[7:0],
                  (current_command == snfcs_pkg::OP_SERASE) ||
                  (current_command == snfcs_pkg::OP_READ && bytes_left == '0), 8'h00};
                n = 2'd1;
              end else if (current_command == snfcs_pkg::OP_READ) begin
                if (bytes_left != '0) begin
                  phase_next = snfcs_pkg::PH_RD;
                  buf_next[0] = '{snfcs_pkg::RK_XFER, 8'h00,
                                  bytes_left == CB'(1), 8'h00};
                  n = 2'd1;
                end else begin
                  ent = snfcs_pkg::PH_FINISH;
                end
              end else if (current_command == snfcs_pkg::OP_PROG) begin
                phase_next = snfcs_pkg::PH_WAITH;
                buf_next[0] = '{snfcs_pkg::RK_REQ, 8'h00, 1'b0, 8'h00};
                n = 2'd1;
              end else begin
                bl_sub = {1'b0, bytes_left} - (CB+1)'(step);
                if (step > (AB+1)'(bytes_left)) begin
                  bytes_left_next = '0;
                end else begin
                  bytes_left_next = bl_sub[CB-1:0];
                end
                cursor_addr_next = cursor_addr + step[AB-1:0];
                resume_phase_next = snfcs_pkg::PH_NEXT;
                ent = snfcs_pkg::PH_POLLC;
              end
            end
            snfcs_pkg::PH_RD: begin
              buf_next[0] = '{snfcs_pkg::RK_RDATA, 8'h00, 1'b0, q_item.rx_byte};
              if (bytes_left > CB'(1)) begin
                bytes_left_next = bytes_left - CB'(1);
                buf_next[1] = '{snfcs_pkg::RK_XFER, 8'h00,
                                bytes_left == CB'(2), 8'h00};
                n = 2'd2;
              end else begin
                bytes_left_next = '0;
                buf_next[1] = '{snfcs_pkg::RK_DONE, 8'h00, 1'b0, 8'h00};
                phase_next = snfcs_pkg::PH_IDLE;
                n = 2'd2;
              end
            end
            snfcs_pkg::PH_WD: begin
              if (chunk_left != '0) chunk_left_next = chunk_left - HB'(1);
              if (bytes_left != '0) bytes_left_next = bytes_left - CB'(1);
              cursor_addr_next = cursor_addr + AB'(1);
              if (chunk_left > HB'(1)) begin
                phase_next = snfcs_pkg::PH_WAITH;
                buf_next[0] = '{snfcs_pkg::RK_REQ, 8'h00, 1'b0, 8'h00};
                n = 2'd1;
              end else begin
                resume_phase_next = snfcs_pkg::PH_NEXT;
                ent = snfcs_pkg::PH_POLLC;
              end
            end
            snfcs_pkg::PH_TAIL: ent = snfcs_pkg::PH_FINISH;
            default: ;
          endcase
        end
        default: ;
      endcase

      // Resolve a chunk boundary before the entry action
      if (ent == snfcs_pkg::PH_NEXT) begin
        if (bytes_left_next == '0) begin
          ent = snfcs_pkg::PH_FINISH;
        end else begin
          if (current_command_next == snfcs_pkg::OP_PROG) begin
            room = AB'(snfcs_pkg::PageBytes) -
                   {{(AB-snfcs_pkg::PageBits){1'b0}},
                    cursor_addr_next[snfcs_pkg::PageBits-1:0]};
            rm = room[HB-1:0];
            if ({{(AB-CB){1'b0}}, bytes_left_next} < room) begin
              chunk_left_next = bytes_left_next[HB-1:0];
            end else begin
              chunk_left_next = rm;
            end
          end
          ent = snfcs_pkg::PH_WREN;
        end
      end

      // Entry action appends one word
      if (ent != snfcs_pkg::PH_IDLE) begin
        case (ent)
          snfcs_pkg::PH_WREN: begin
            phase_next = snfcs_pkg::PH_WREN;
            buf_next[n] = '{snfcs_pkg::RK_XFER, snfcs_pkg::FL_WREN, 1'b1, 8'h00};
          end
          snfcs_pkg::PH_POLLC: begin
            phase_next = snfcs_pkg::PH_POLLC;
            buf_next[n] = '{snfcs_pkg::RK_XFER, snfcs_pkg::FL_RDSR, 1'b0, 8'h00};
          end
          snfcs_pkg::PH_CMD: begin
            phase_next = snfcs_pkg::PH_CMD;
            frame_pos_next = '0;
            case (current_command_next)
              snfcs_pkg::OP_READ: opb = snfcs_pkg::FL_READ;
              snfcs_pkg::OP_PROG: opb = snfcs_pkg::FL_PP;
              snfcs_pkg::OP_SERASE: opb = erase_opcode;
              snfcs_pkg::OP_CERASE: opb = snfcs_pkg::FL_CE;
              snfcs_pkg::OP_WRSR: opb = snfcs_pkg::FL_WRSR;
              snfcs_pkg::OP_RDSR: opb = snfcs_pkg::FL_RDSR;
              default: opb = snfcs_pkg::FL_RDID;
            endcase
            buf_next[n] = '{snfcs_pkg::RK_XFER, opb,
                            current_command_next == snfcs_pkg::OP_CERASE, 8'h00};
          end
          default: begin
            phase_next = snfcs_pkg::PH_IDLE;
            buf_next[n] = '{snfcs_pkg::RK_DONE, 8'h00, 1'b0, 8'h00};
          end
        endcase
        n = n + 2'd1;
      end
    end
    buf_cnt_next = take ? n : buf_cnt;
  end

  // Hold sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= snfcs_pkg::PH_IDLE;
      resume_phase <= snfcs_pkg::PH_IDLE;
      current_command <= '0;
      cursor_addr <= '0;
      bytes_left <= '0;
      chunk_left <= '0;
      frame_pos <= '0;
    end else begin
      phase <= phase_next;
      resume_phase <= resume_phase_next;
      current_command <= current_command_next;
      cursor_addr <= cursor_addr_next;
      bytes_left <= bytes_left_next;
      chunk_left <= chunk_left_next;
      frame_pos <= frame_pos_next;
    end
  end

  // Load and drain the result buffer
  always_ff @(posedge clk) begin
    if (take) begin
      buf_res <= buf_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_cnt <= '0;
      buf_rd <= '0;
    end else if (take) begin
      buf_cnt <= buf_cnt_next;
      buf_rd <= '0;
    end else if (out_valid && !out_stall) begin
      if (out_last) begin
        buf_cnt <= '0;
        buf_rd <= '0;
      end else begin
        buf_rd <= buf_rd + 2'd1;
      end
    end
  end

  `ASSERT_CLK(a_phase_onehot, clk, rst, $onehot(phase), "phase not one-hot")
  `ASSERT_CLK(a_no_pop_busy, clk, rst, !q_pop || !out_valid || (out_last && !out_stall), "pop while results pending")
  `ASSERT_CLK(a_rd_in_range, clk, rst, !out_valid || (buf_rd < buf_cnt), "read past buffer")

endmodule

>>> hw/rtl/spi_nor_flash_command_sequencer.sv
// Top level of the SPI NOR flash command sequencer
// Each word is registered in the front queue, then its results in the engine result buffer.
// Throughput: one input word per cycle into a two-entry queue unless in_stall; the engine takes the
// next word when its buffer is empty or in the cycle the last result of the previous one leaves.
// Results, up to two per word, leave the engine buffer one per cycle unless out_stall.
// Synchronous active-high reset clears state to idle and config to 0x20 / 12.
module spi_nor_flash_command_sequencer (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [7:0] cfg_data,
  input  logic in_valid,
  output logic in_stall,
  input  logic [1:0] func,
  input  logic [2:0] op,
  input  logic [23:0] start_addr,
  input  logic [15:0] byte_count,
  input  logic [7:0] wdata,
  input  logic [7:0] rx_byte,
  output logic out_valid,
  input  logic out_stall,
  output logic [1:0] result_kind,
  output logic [7:0] tx_byte,
  output logic frame_end,
  output logic [7:0] rd_byte,
  output logic last
);

  snfcs_pkg::item_t in_item;
  snfcs_pkg::item_t q_item;
  snfcs_pkg::res_t res;
  logic q_valid;
  logic q_pop;

  assign in_item = '{func, op, start_addr, byte_count, wdata, rx_byte};
  assign result_kind = res.kind;
  assign tx_byte = res.tx;
  assign frame_end = res.fe;
  assign rd_byte = res.rd;

  snfcs_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .in_item(in_item), .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item)
  );

  snfcs_engine u_engine (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_res(res), .out_last(last)
  );

endmodule

>>> bench/spi_nor_flash_command_sequencer_test.sv
// Testbench for the SPI NOR flash command sequencer: flash protocol predictor and result check
`timescale 1ns / 100ps

module spi_nor_flash_command_sequencer_test;

  typedef struct packed {
    logic [1:0] func;
    logic [2:0] op;
    logic [23:0] start_addr;
    logic [15:0] byte_count;
    logic [7:0] wdata;
    logic [7:0] rx_byte;
  } word_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] tx;
    logic fe;
    logic [7:0] rd;
    logic lst;
  } flash_res_t;

  typedef enum int {
    S_IDLE, S_WREN, S_POLLC, S_POLLD, S_CMD, S_ADDR, S_RD, S_WAITH, S_WD,
    S_NEXT, S_TAIL, S_FINISH
  } seq_phase_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_index = snfcs_pkg::CFG_ERASE_OP;
  logic [7:0] cfg_data = 8'd0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] func = snfcs_pkg::FUNC_CMD;
  logic [2:0] op = snfcs_pkg::OP_READ;
  logic [23:0] start_addr = 24'd0;
  logic [15:0] byte_count = 16'd0;
  logic [7:0] wdata = 8'd0;
  logic [7:0] rx_byte = 8'd0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] result_kind;
  logic [7:0] tx_byte;
  logic frame_end;
  logic [7:0] rd_byte;
  logic last;

  spi_nor_flash_command_sequencer uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state
  logic [7:0] p_erase_op = 8'h20;
  logic [4:0] p_shift = 5'd12;
  seq_phase_t p_phase = S_IDLE;
  seq_phase_t p_resume = S_IDLE;
  logic [2:0] p_cmd = 3'd0;
  logic [23:0] p_addr = 24'd0;
  logic [15:0] p_left = 16'd0;
  logic [8:0] p_chunk = 9'd0;
  logic [2:0] p_pos = 3'd0;

  word_t pending_words[$];
  flash_res_t expected_results[$];
  flash_res_t step_results[$];
  int errors = 0;
  bit long_req = 1'b0;
  bit long_done = 1'b0;
  int long_count = 0;

  task automatic report(input string msg);
    $display("tb: mismatch: %s", msg);
    errors++;
  endtask

  function automatic void emit(input logic [1:0] k, input logic [7:0] t,
                               input logic f, input logic [7:0] r);
    step_results.push_back('{k, t, f, r, 1'b0});
  endfunction

  function automatic void send_dummy();
    p_phase = S_RD;
    emit(snfcs_pkg::RK_XFER, 8'h00, p_left == 16'd1, 8'h00);
  endfunction

  function automatic void enter_phase(input seq_phase_t ph);
    logic [8:0] room;
    logic [7:0] opc;
    case (ph)
      S_WREN: begin
        p_phase = S_WREN;
        emit(snfcs_pkg::RK_XFER, snfcs_pkg::FL_WREN, 1'b1, 8'h00);
      end
      S_POLLC: begin
        p_phase = S_POLLC;
        emit(snfcs_pkg::RK_XFER, snfcs_pkg::FL_RDSR, 1'b0, 8'h00);
      end
      S_CMD: begin
        p_phase = S_CMD;
        p_pos = 3'd0;
        case (p_cmd)
          snfcs_pkg::OP_READ: opc = snfcs_pkg::FL_READ;
          snfcs_pkg::OP_PROG: opc = snfcs_pkg::FL_PP;
          snfcs_pkg::OP_SERASE: opc = p_erase_op;
          snfcs_pkg::OP_CERASE: opc = snfcs_pkg::FL_CE;
          snfcs_pkg::OP_WRSR: opc = snfcs_pkg::FL_WRSR;
          snfcs_pkg::OP_RDSR: opc = snfcs_pkg::FL_RDSR;
          default: opc = snfcs_pkg::FL_RDID;
        endcase
        emit(snfcs_pkg::RK_XFER, opc, p_cmd == snfcs_pkg::OP_CERASE, 8'h00);
      end
      S_NEXT: begin
        if (p_left == 16'd0) begin
          enter_phase(S_FINISH);
        end else begin
          if (p_cmd == snfcs_pkg::OP_PROG) begin
            room = 9'd256 - {1'b0, p_addr[7:0]};
            p_chunk = (p_left < {7'd0, room}) ? p_left[8:0] : room;
          end
          enter_phase(S_WREN);
        end
      end
      default: begin
        p_phase = S_IDLE;
        emit(snfcs_pkg::RK_DONE, 8'h00, 1'b0, 8'h00);
      end
    endcase
  endfunction

  function automatic void start_poll(input seq_phase_t resume);
    p_resume = resume;
    enter_phase(S_POLLC);
  endfunction

  function automatic void on_received(input logic [7:0] rx);
    logic [32:0] stride;
    case (p_phase)
      S_WREN: start_poll(S_CMD);
      S_POLLC: begin
        p_phase = S_POLLD;
        emit(snfcs_pkg::RK_XFER, 8'h00, 1'b1, 8'h00);
      end
      S_POLLD: begin
        if (rx[0]) enter_phase(S_POLLC);
        else enter_phase(p_resume);
      end
      S_CMD: begin
        case (p_cmd)
          snfcs_pkg::OP_READ, snfcs_pkg::OP_PROG, snfcs_pkg::OP_SERASE: begin
            p_phase = S_ADDR;
            p_pos = 3'd0;
            emit(snfcs_pkg::RK_XFER, p_addr[23:16], 1'b0, 8'h00);
          end
          snfcs_pkg::OP_CERASE: start_poll(S_FINISH);
          snfcs_pkg::OP_WRSR: begin
            p_phase = S_TAIL;
            emit(snfcs_pkg::RK_XFER, p_addr[7:0], 1'b1, 8'h00);
          end
          default: send_dummy();
        endcase
      end
      S_ADDR: begin
        p_pos = p_pos + 3'd1;
        if (p_pos < 3'd3) begin
          emit(snfcs_pkg::RK_XFER, p_pos == 3'd1 ? p_addr[15:8] : p_addr[7:0],
               (p_pos == 3'd2) && (p_cmd == snfcs_pkg::OP_SERASE ||
               (p_cmd == snfcs_pkg::OP_READ && p_left == 16'd0)), 8'h00);
        end else if (p_cmd == snfcs_pkg::OP_READ) begin
          if (p_left != 16'd0) send_dummy();
          else enter_phase(S_FINISH);
        end else if (p_cmd == snfcs_pkg::OP_PROG) begin
          p_phase = S_WAITH;
          emit(snfcs_pkg::RK_REQ, 8'h00, 1'b0, 8'h00);
        end else begin
          stride = 33'd1 << p_shift;
          p_left = ({17'd0, p_left} <= stride) ? 16'd0 : p_left - stride[15:0];
          p_addr = p_addr + stride[23:0];
          start_poll(S_NEXT);
        end
      end
      S_RD: begin
        emit(snfcs_pkg::RK_RDATA, 8'h00, 1'b0, rx);
        if (p_left != 16'd0) p_left--;
        if (p_left != 16'd0) send_dummy();
        else enter_phase(S_FINISH);
      end
      S_WD: begin
        if (p_chunk != 9'd0) p_chunk--;
        if (p_left != 16'd0) p_left--;
        p_addr = p_addr + 24'd1;
        if (p_chunk != 9'd0) begin
          p_phase = S_WAITH;
          emit(snfcs_pkg::RK_REQ, 8'h00, 1'b0, 8'h00);
        end else begin
          start_poll(S_NEXT);
        end
      end
      S_TAIL: enter_phase(S_FINISH);
      default: ;
    endcase
  endfunction

  // Work out the results caused by one accepted word
  function automatic void predict_word(input word_t w);
    flash_res_t r;
    step_results.delete();
    if (w.func == snfcs_pkg::FUNC_CMD) begin
      if (p_phase == S_IDLE) begin
        p_cmd = w.op;
        p_addr = w.start_addr;
        p_left = w.byte_count;
        p_chunk = 9'd0;
        p_pos = 3'd0;
        case (w.op)
          snfcs_pkg::OP_READ: enter_phase(S_CMD);
          snfcs_pkg::OP_PROG, snfcs_pkg::OP_SERASE: enter_phase(S_NEXT);
          snfcs_pkg::OP_CERASE: enter_phase(S_WREN);
          snfcs_pkg::OP_WRSR: begin
            p_addr = {16'd0, w.wdata};
            enter_phase(S_WREN);
          end
          snfcs_pkg::OP_RDSR: begin
            p_left = 16'd1;
            enter_phase(S_CMD);
          end
          snfcs_pkg::OP_RDID: begin
            p_left = 16'd3;
            start_poll(S_CMD);
          end
          default: enter_phase(S_FINISH);
        endcase
      end
    end else if (w.func == snfcs_pkg::FUNC_DATA) begin
      if (p_phase == S_WAITH) begin
        p_phase = S_WD;
        emit(snfcs_pkg::RK_XFER, w.wdata, p_chunk == 9'd1, 8'h00);
      end
    end else if (w.func == snfcs_pkg::FUNC_RX) begin
      on_received(w.rx_byte);
    end
    for (int i = 0; i < step_results.size(); i++) begin
      r = step_results[i];
      r.lst = (i == step_results.size() - 1);
      expected_results.push_back(r);
    end
  endfunction

  function automatic word_t mk(input logic [1:0] f, input logic [2:0] o,
                               input logic [23:0] a, input logic [15:0] n,
                               input logic [7:0] d, input logic [7:0] rx);
    return '{f, o, a, n, d, rx};
  endfunction

  // Reply word with junk in the fields that do not matter
  function automatic word_t mk_reply(input logic [1:0] f, input logic [7:0] d,
                                     input logic [7:0] rx);
    return mk(f, 3'($urandom), 24'($urandom), 16'($urandom), d, rx);
  endfunction

  function automatic word_t rand_word();
    return mk(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)), 24'($urandom),
              16'($urandom_range(0, 2)), 8'($urandom), 8'($urandom));
  endfunction

  // Queue a full command word
  task automatic queue_command(input logic [2:0] o, input logic [23:0] a,
                               input logic [15:0] n, input logic [7:0] d);
    pending_words.push_back(mk(snfcs_pkg::FUNC_CMD, o, a, n, d, 8'($urandom)));
  endtask

  // Driver: next word in the accepting cycle or after a random gap
  int gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        predict_word({func, op, start_addr, byte_count, wdata, rx_byte});
        gap = $urandom_range(0, 11);
        if ($urandom_range(0, 3) == 0) gap = 0;
      end
      if (gap > 0) begin
        gap--;
        in_valid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        {func, op, start_addr, byte_count, wdata, rx_byte} <= pending_words.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted on its own
  always @(posedge clk) begin
    if (long_req && !long_done) begin
      if (long_count == 60) long_done <= 1'b1;
      else long_count <= long_count + 1;
    end
  end

  // Monitor: random stall, compare field by field
  int hold = 0;
  flash_res_t exp_r;
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report($sformatf("unexpected result kind %0d tx %h", result_kind, tx_byte));
        end else begin
          exp_r = expected_results.pop_front();
          if (result_kind !== exp_r.kind) report($sformatf("kind %0d want %0d",
            result_kind, exp_r.kind));
          if (tx_byte !== exp_r.tx) report($sformatf("tx %h want %h", tx_byte, exp_r.tx));
          if (frame_end !== exp_r.fe) report($sformatf("frame_end %b want %b",
            frame_end, exp_r.fe));
          if (rd_byte !== exp_r.rd) report($sformatf("rd %h want %h", rd_byte, exp_r.rd));
          if (last !== exp_r.lst) report($sformatf("last %b want %b", last, exp_r.lst));
        end
        hold = $urandom_range(0, 11);
        if ($urandom_range(0, 3) == 0) hold = 0;
      end
      if (long_req && !long_done) begin
        out_stall <= 1'b1;
      end else if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Pause until every queued word is sent and every expected result is seen
  task automatic wait_idle();
    @(negedge clk);
    while (pending_words.size() > 0 || in_valid || expected_results.size() > 0)
      @(negedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_cfg(input logic idx, input logic [7:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == snfcs_pkg::CFG_ERASE_OP) p_erase_op = v;
    else p_shift = v[4:0];
  endtask

  // Play the flash side of a command: answer transfers from predicted state
  task automatic run_session(input logic [2:0] o, input logic [23:0] a,
                             input logic [15:0] n, input int noise);
    int guard;
    queue_command(o, a, n, 8'($urandom));
    wait_idle();
    guard = 0;
    while (p_phase != S_IDLE && guard < 400) begin
      guard++;
      if (noise > 0 && $urandom_range(0, 19) == 0)
        pending_words.push_back(rand_word());
      if (p_phase == S_WAITH)
        pending_words.push_back(mk_reply(snfcs_pkg::FUNC_DATA, 8'($urandom),
                                         8'($urandom)));
      else if (p_phase == S_POLLD)
        pending_words.push_back(mk_reply(snfcs_pkg::FUNC_RX, 8'($urandom),
          {7'($urandom_range(0, 127)), $urandom_range(0, 3) == 0}));
      else
        pending_words.push_back(mk_reply(snfcs_pkg::FUNC_RX, 8'($urandom),
                                         8'($urandom)));
      wait_idle();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Directed: every command, zero counts, stray words, unused codes
    pending_words.push_back(mk(snfcs_pkg::FUNC_DATA, snfcs_pkg::OP_READ, 24'd0, 16'd0,
                               8'hff, 8'h00));
    pending_words.push_back(mk(snfcs_pkg::FUNC_RX, snfcs_pkg::OP_READ, 24'd0, 16'd0,
                               8'h00, 8'hff));
    pending_words.push_back(mk(snfcs_pkg::FUNC_RSVD, snfcs_pkg::OP_NOP, 24'hffffff,
                               16'hffff, 8'hff, 8'hff));
    pending_words.push_back(mk(snfcs_pkg::FUNC_CMD, snfcs_pkg::OP_NOP, 24'd0, 16'd0,
                               8'h00, 8'h00));
    wait_idle();
    run_session(snfcs_pkg::OP_READ, 24'hffffff, 16'd0, 0);
    run_session(snfcs_pkg::OP_READ, 24'h123456, 16'd2, 0);
    run_session(snfcs_pkg::OP_PROG, 24'h0000fe, 16'd0, 0);
    run_session(snfcs_pkg::OP_PROG, 24'h0000fe, 16'd3, 0);
    run_session(snfcs_pkg::OP_SERASE, 24'hfff000, 16'd0, 0);
    run_session(snfcs_pkg::OP_SERASE, 24'hfff000, 16'h1000, 0);
    run_session(snfcs_pkg::OP_CERASE, 24'd0, 16'd0, 0);
    run_session(snfcs_pkg::OP_WRSR, 24'd0, 16'd0, 0);
    run_session(snfcs_pkg::OP_RDSR, 24'd0, 16'd0, 0);
    run_session(snfcs_pkg::OP_RDID, 24'd0, 16'd0, 0);
    // Sector erase settings, extremes included
    write_cfg(snfcs_pkg::CFG_ERASE_OP, 8'hd8);
    write_cfg(snfcs_pkg::CFG_SECT_SHIFT, 8'd31);
    run_session(snfcs_pkg::OP_SERASE, 24'h000100, 16'h0100, 0);
    write_cfg(snfcs_pkg::CFG_ERASE_OP, 8'h00);
    write_cfg(snfcs_pkg::CFG_SECT_SHIFT, 8'd1);
    run_session(snfcs_pkg::OP_SERASE, 24'hfffffe, 16'd3, 0);
    write_cfg(snfcs_pkg::CFG_ERASE_OP, 8'h52);
    write_cfg(snfcs_pkg::CFG_SECT_SHIFT, 8'd13);
    // Back pressure: stall results long while words keep coming
    long_req = 1'b1;
    for (int i = 0; i < 6; i++)
      pending_words.push_back(mk(snfcs_pkg::FUNC_CMD, snfcs_pkg::OP_NOP, 24'd0, 16'd0,
                                 8'h00, 8'h00));
    wait_idle();
    // Random commands with well-formed flash replies and some noise
    for (int i = 0; i < 2; i++) begin
      logic [2:0] o;
      logic [15:0] n;
      o = 3'($urandom_range(0, 7));
      n = 16'($urandom_range(0, 2));
      run_session(o, 24'($urandom), n, 1);
    end
    for (int i = 0; i < 6; i++) pending_words.push_back(rand_word());
    wait_idle();
    while (p_phase != S_IDLE) run_session(snfcs_pkg::OP_NOP, 24'd0, 16'd0, 0);
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end
endmodule

>>> spi_nor_flash_command_sequencer.f
+incdir+hw/rtl
hw/rtl/snfcs_pkg.sv
hw/rtl/snfcs_front.sv
hw/rtl/snfcs_engine.sv
hw/rtl/spi_nor_flash_command_sequencer.sv
bench/spi_nor_flash_command_sequencer_test.sv
